// ===== rtl/core/hid_descriptor_usage_page_finder_top_assert.svh =====
// assertion macros for the hid descriptor usage page finder
// needs clk_i and rst_ni in the scope that uses them
`ifndef HID_DESCRIPTOR_USAGE_PAGE_FINDER_TOP_ASSERT_SVH
`define HID_DESCRIPTOR_USAGE_PAGE_FINDER_TOP_ASSERT_SVH

// clocked assertion, off while reset is held
`define HDUPF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// clocked assertion that also holds during reset
`define HDUPF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== rtl/core/hdupf_pkg.sv =====
// shared types and constants for the hid descriptor usage page finder
// no dependencies
`default_nettype none

package hdupf_pkg;

  // descriptor byte decode
  localparam logic [7:0] LONG_MASK   = 8'hF0;
  localparam logic [7:0] SIZE_MASK   = 8'h03;
  localparam logic [7:0] PAGE_MASK   = 8'hFC;
  localparam logic [7:0] PAGE_PREFIX = 8'h04;

  // search status codes
  localparam logic [1:0] ST_NOT_FOUND = 2'd0;
  localparam logic [1:0] ST_FOUND     = 2'd1;
  localparam logic [1:0] ST_TRUNCATED = 2'd2;

  typedef enum logic [1:0] {
    PH_HEADER   = 2'd0,
    PH_LONG_LEN = 2'd1,
    PH_LONG_TAG = 2'd2,
    PH_DATA     = 2'd3
  } phase_e;

  // one registered descriptor byte
  typedef struct packed {
    logic       last;
    logic [7:0] data;
  } beat_t;

  // one search result
  typedef struct packed {
    logic       valid;
    logic [1:0] status;
  } res_t;

  // short item size code to data byte count
  function automatic logic [2:0] size_bytes(input logic [1:0] code);
    logic [2:0] n;
    case (code)
      2'd0:    n = 3'd0;
      2'd1:    n = 3'd1;
      2'd2:    n = 3'd2;
      default: n = 3'd4;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/hdupf_in_reg.sv =====
// input register stage for the usage page finder
// depends on hdupf_pkg
`default_nettype none

module hdupf_in_reg (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire logic [7:0]    desc_byte_i,
  input  wire logic          last_byte_i,
  input  wire logic          out_free_i,
  output logic               fire_o,
  output hdupf_pkg::beat_t   beat_o
);
  import hdupf_pkg::*;

  logic  valid_q, valid_d;
  beat_t beat_q;
  logic  accept;

  // only a last byte needs room in the result register
  assign fire_o     = valid_q && (!beat_q.last || out_free_i);
  assign in_stall_o = valid_q && !fire_o;
  assign accept     = in_valid_i && !in_stall_o;
  assign beat_o     = beat_q;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (fire_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      beat_q.data <= desc_byte_i;
      beat_q.last <= last_byte_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/hdupf_parser.sv =====
// item parser state and usage page match for the usage page finder
// depends on hdupf_pkg
`default_nettype none

module hdupf_parser (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cfg_valid_i,
  input  wire logic [15:0]   cfg_data_i,
  input  wire logic          fire_i,
  input  hdupf_pkg::beat_t   beat_i,
  output hdupf_pkg::res_t    res_o
);
  import hdupf_pkg::*;

  logic [15:0] target_q;
  phase_e      phase_q, phase_d;
  logic [7:0]  left_q, left_d;
  logic        page_q, page_d;
  logic [31:0] accum_q, accum_d;
  logic [1:0]  pos_q, pos_d;
  logic        found_q, found_d;
  logic [7:0]  b;
  logic [1:0]  size_code;
  logic [31:0] lane_val;
  logic        page_hdr;

  assign b         = beat_i.data;
  assign size_code = 2'(b & SIZE_MASK);
  assign lane_val  = 32'(b) << {pos_q, 3'b000};
  assign page_hdr  = (b & PAGE_MASK) == PAGE_PREFIX;

  always_comb begin
    phase_d = phase_q;
    left_d  = left_q;
    page_d  = page_q;
    accum_d = accum_q;
    pos_d   = pos_q;
    found_d = found_q;
    res_o   = '0;
    if (fire_i) begin
      // once found, bytes up to the end are ignored
      if (!found_q) begin
        case (phase_q)
          PH_HEADER: begin
            if ((b & LONG_MASK) == LONG_MASK) begin
              phase_d = PH_LONG_LEN;
            end else begin
              page_d  = page_hdr;
              accum_d = '0;
              pos_d   = '0;
              if (size_code == 2'd0) begin
                // empty usage page has the value zero
                if (page_hdr && target_q == '0) begin
                  found_d = 1'b1;
                end
                page_d = 1'b0;
              end else begin
                left_d  = 8'(size_bytes(size_code));
                phase_d = PH_DATA;
              end
            end
          end
          PH_LONG_LEN: begin
            left_d  = b;
            phase_d = PH_LONG_TAG;
          end
          PH_LONG_TAG: begin
            page_d  = 1'b0;
            phase_d = (left_q != '0) ? PH_DATA : PH_HEADER;
          end
          PH_DATA: begin
            if (page_q) begin
              accum_d = accum_q | lane_val;
              pos_d   = pos_q + 2'd1;
            end
            if (left_q != '0) begin
              left_d = left_q - 8'd1;
            end
            if (left_d == '0) begin
              phase_d = PH_HEADER;
              if (page_q && accum_d == {16'b0, target_q}) begin
                found_d = 1'b1;
              end
              page_d = 1'b0;
            end
          end
          default: begin
            phase_d = PH_HEADER;
          end
        endcase
      end
      if (beat_i.last) begin
        res_o.valid = 1'b1;
        if (found_d) begin
          res_o.status = ST_FOUND;
        end else if (phase_d == PH_DATA && page_d) begin
          res_o.status = ST_TRUNCATED;
        end else begin
          res_o.status = ST_NOT_FOUND;
        end
        // back to the start for the next descriptor
        phase_d = PH_HEADER;
        left_d  = '0;
        page_d  = 1'b0;
        accum_d = '0;
        pos_d   = '0;
        found_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= '0;
      phase_q  <= PH_HEADER;
      left_q   <= '0;
      page_q   <= 1'b0;
      accum_q  <= '0;
      pos_q    <= '0;
      found_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        target_q <= cfg_data_i;
      end
      phase_q <= phase_d;
      left_q  <= left_d;
      page_q  <= page_d;
      accum_q <= accum_d;
      pos_q   <= pos_d;
      found_q <= found_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/hdupf_out_reg.sv =====
// result register for the usage page finder
// depends on hdupf_pkg
`default_nettype none

module hdupf_out_reg (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  hdupf_pkg::res_t  res_i,
  output logic             out_free_o,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       search_status_o
);
  import hdupf_pkg::*;

  logic       valid_q, valid_d;
  logic [1:0] status_q;

  assign out_free_o      = !valid_q || !out_stall_i;
  assign out_valid_o     = valid_q;
  assign search_status_o = status_q;

  always_comb begin
    valid_d = valid_q && out_stall_i;
    if (res_i.valid) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_i.valid) begin
      status_q <= res_i.status;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/hid_descriptor_usage_page_finder_top.sv =====
// top level of the hid report descriptor usage page finder
// depends on hdupf_pkg, hdupf_in_reg, hdupf_parser, hdupf_out_reg
`default_nettype none

// usage:
//   input channel: one descriptor byte per transaction (desc_byte_i) with
//   last_byte_i marking the final byte; a transaction completes when
//   in_valid_i is high and in_stall_o is low
//   output channel: one search_status_o transaction per descriptor, issued
//   for the last byte only (0 not found, 1 found, 2 truncated usage page)
//   config channel: target_usage_page_i is written when cfg_valid_i and
//   cfg_ready_o are high; ready is always high, write only while idle
// path: a last byte goes from the input register to the result register
// throughput: one byte per cycle while in_stall_o is low; the parse state
//   update is a single registered pass between the input register and the result register
// stall: while the result register holds an untaken result, non-last bytes
//   still flow; a last byte waits in the input register and in_stall_o rises
// reset: clears the parse state, the valid flags and the target page
//   (target resets to zero); no clearing pass is needed
module hid_descriptor_usage_page_finder_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // descriptor byte channel
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  desc_byte_i,
  input  wire logic        last_byte_i,
  // result channel
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       search_status_o,
  // target page register
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [15:0] target_usage_page_i
);
  import hdupf_pkg::*;

  logic  fire;
  logic  out_free;
  beat_t beat;
  res_t  res;

  // register writes never wait
  assign cfg_ready_o = 1'b1;

  // stage one: registered input byte
  hdupf_in_reg u_in_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .desc_byte_i (desc_byte_i),
    .last_byte_i (last_byte_i),
    .out_free_i  (out_free),
    .fire_o      (fire),
    .beat_o      (beat)
  );

  // item walk, page gather and compare
  hdupf_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (target_usage_page_i),
    .fire_i      (fire),
    .beat_i      (beat),
    .res_o       (res)
  );

  // stage two: result register toward the receiver
  hdupf_out_reg u_out_reg (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .res_i           (res),
    .out_free_o      (out_free),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .search_status_o (search_status_o)
  );

endmodule

`default_nettype wire

// ===== rtl/core/hdupf_checker.sv =====
// port level checks for the usage page finder, bound to the top level
// depends on hid_descriptor_usage_page_finder_top_assert.svh
`default_nettype none

`include "hid_descriptor_usage_page_finder_top_assert.svh"

module hdupf_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_stall_o,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic [1:0] search_status_o
);

  // a held result keeps its status
  `HDUPF_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(search_status_o), "result changed while stalled")

  // only the three status codes are ever shown
  `HDUPF_ASSERT(a_status_code, out_valid_o |-> search_status_o != 2'd3, "bad status code")

  // the input side only backs up behind a blocked result
  `HDUPF_ASSERT(a_stall_cause, in_stall_o |-> out_valid_o && out_stall_i, "input stalled without blocked result")

  // nothing is pending right out of reset
  `HDUPF_ASSERT_ALWAYS(a_reset_idle, !rst_ni |=> !out_valid_o || !rst_ni, "result valid after reset")

endmodule

bind hid_descriptor_usage_page_finder_top hdupf_checker u_hdupf_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .search_status_o (search_status_o)
);

`default_nettype wire

// ===== dv/hid_descriptor_usage_page_finder_top_test.sv =====
// self-checking testbench for hid_descriptor_usage_page_finder_top
// needs hdupf_pkg and the finder rtl; a built-in parser predicts every status
`timescale 1ns / 1ps

module hid_descriptor_usage_page_finder_top_test;
  import hdupf_pkg::*;

  localparam int RandomBytes  = 1700;
  localparam int MaxWait      = 11;
  // an accepted last byte passes the input and result registers to the port
  localparam int SettleCycles = 6;

  // clock and reset
  logic clk_i = 1'b0;
  logic rst_ni;

  always #1 clk_i = ~clk_i;

  // block ports
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  desc_byte_i;
  logic        last_byte_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [1:0]  search_status_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [15:0] target_usage_page_i;

  hid_descriptor_usage_page_finder_top dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .desc_byte_i        (desc_byte_i),
    .last_byte_i        (last_byte_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .search_status_o    (search_status_o),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .target_usage_page_i(target_usage_page_i)
  );

  // shared bookkeeping
  logic [1:0] expected_status_q[$];
  logic [7:0] desc_buf[$];
  int         fail_count = 0;
  int         bytes_sent = 0;
  int         rx_wait    = 0;
  bit         quiet      = 1'b0;  // no idling on either side while set

  // mirror of the parser: one copy of the target page and the walk state
  logic [15:0] target_page;
  phase_e      parse_ph;
  logic [7:0]  left_cnt;
  logic        page_item;
  logic [31:0] page_val;
  logic [1:0]  lane;
  logic        settled;
  logic [1:0]  settled_st;

  function automatic int draw_wait();
    return quiet ? 0 : $urandom_range(0, MaxWait);
  endfunction

  // back to the start of a descriptor, target page untouched
  function automatic void clear_parse_state();
    parse_ph   = PH_HEADER;
    left_cnt   = '0;
    page_item  = 1'b0;
    page_val   = '0;
    lane       = '0;
    settled    = 1'b0;
    settled_st = ST_NOT_FOUND;
  endfunction

  // a finished usage page item settles the search on a match
  function automatic void close_item();
    if (page_item && page_val == {16'd0, target_page}) begin
      settled    = 1'b1;
      settled_st = ST_FOUND;
    end
    page_item = 1'b0;
  endfunction

  // walk one descriptor byte through the item grammar
  function automatic void parse_byte(input logic [7:0] b);
    logic [7:0] n;
    case (parse_ph)
      PH_HEADER: begin
        if ((b & LONG_MASK) == LONG_MASK) begin
          parse_ph = PH_LONG_LEN;
        end else begin
          // size code 3 stands for four data bytes
          n         = (b[1:0] == 2'd3) ? 8'd4 : {6'd0, b[1:0]};
          page_item = ((b & PAGE_MASK) == PAGE_PREFIX);
          page_val  = '0;
          lane      = '0;
          if (n == 8'd0) begin
            close_item();
          end else begin
            left_cnt = n;
            parse_ph = PH_DATA;
          end
        end
      end
      PH_LONG_LEN: begin
        left_cnt = b;
        parse_ph = PH_LONG_TAG;
      end
      PH_LONG_TAG: begin
        page_item = 1'b0;
        parse_ph  = (left_cnt != 8'd0) ? PH_DATA : PH_HEADER;
      end
      default: begin
        if (page_item) begin
          page_val = page_val | ({24'd0, b} << (8 * lane));
          lane     = lane + 2'd1;
        end
        if (left_cnt != 8'd0) left_cnt = left_cnt - 8'd1;
        if (left_cnt == 8'd0) begin
          parse_ph = PH_HEADER;
          close_item();
        end
      end
    endcase
  endfunction

  // accepted byte: advance the mirror, queue a status on the last byte
  function automatic void track_descriptor_byte(input logic [7:0] b, input logic last);
    if (!settled) parse_byte(b);
    if (last) begin
      // a usage page item still open at the end is truncated
      if (!settled && parse_ph == PH_DATA && page_item) begin
        settled    = 1'b1;
        settled_st = ST_TRUNCATED;
      end
      expected_status_q.push_back(settled ? settled_st : ST_NOT_FOUND);
      clear_parse_state();
    end
  endfunction

  // one byte transaction, after a random gap; returns at the accepting edge
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    desc_byte_i <= b;
    last_byte_i <= last;
    do @(posedge clk_i); while (in_stall_o);
    track_descriptor_byte(b, last);
    bytes_sent++;
  endtask

  // the whole buffer as one descriptor, last mark on its final byte
  task automatic send_descriptor();
    int i;
    for (i = 0; i < desc_buf.size(); i++) begin
      send_byte(desc_buf[i], i == desc_buf.size() - 1);
    end
  endtask

  // idle input, every status back, and time for the pipeline to empty
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_status_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // target page write, only once the block has gone quiet
  task automatic program_target(input logic [15:0] page);
    wait_drained();
    cfg_valid_i         <= 1'b1;
    target_usage_page_i <= page;
    do @(posedge clk_i); while (!cfg_ready_o);
    target_page = page;
    cfg_valid_i <= 1'b0;
  endtask

  // result side: random stall per transaction, compare with the oldest status
  always @(posedge clk_i) begin : status_check
    logic [1:0] want_st;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_status_q.size() == 0) begin
          $display("%0t: unexpected status transaction, actual %0d", $time,
                   search_status_o);
          fail_count++;
        end else begin
          want_st = expected_status_q.pop_front();
          if (search_status_o !== want_st) begin
            $display("%0t: search_status mismatch, expected %0d actual %0d", $time,
                     want_st, search_status_o);
            fail_count++;
          end
        end
        rx_wait = draw_wait();
      end else if (out_valid_o && rx_wait != 0) begin
        // stall counts down only while a result is offered
        rx_wait--;
      end
      out_stall_i <= (rx_wait != 0);
    end
  end

  // hand-picked descriptors: extremes of the target, each item kind and
  // several ways a descriptor can end
  task automatic test_directed_items();
    // empty usage page is zero and matches the reset target
    desc_buf = '{8'h04};
    send_descriptor();
    program_target(16'hFFFF);
    // two-byte page at the top of the range
    desc_buf = '{8'h06, 8'hFF, 8'hFF};
    send_descriptor();
    // four-byte page, upper half zero
    desc_buf = '{8'h07, 8'hFF, 8'hFF, 8'h00, 8'h00};
    send_descriptor();
    program_target(16'h0001);
    // a page prefix inside long item data is skipped
    desc_buf = '{8'hFE, 8'h01, 8'h00, 8'h05};
    send_descriptor();
    // zero-length long item, then a matching page
    desc_buf = '{8'hF0, 8'h00, 8'h12, 8'h05, 8'h01};
    send_descriptor();
    // bytes after a match are ignored, even an open page item
    desc_buf = '{8'h05, 8'h01, 8'h06};
    send_descriptor();
    // page item cut off in its data
    desc_buf = '{8'h06, 8'h01};
    send_descriptor();
    // page item cut off right at its prefix
    desc_buf = '{8'h05};
    send_descriptor();
    // other short item cut off
    desc_buf = '{8'h09};
    send_descriptor();
    // long item cut off after its length byte
    desc_buf = '{8'hFF, 8'h05};
    send_descriptor();
  endtask

  // mostly well-formed item lists with random content, some noise bytes
  // and some descriptors cut short at a random byte
  task automatic build_random_descriptor();
    int          n_items, kind, nb, keep, i, j;
    logic [7:0]  pre;
    logic [31:0] val;
    desc_buf.delete();
    n_items = $urandom_range(1, 6);
    for (i = 0; i < n_items; i++) begin
      kind = $urandom_range(0, 15);
      if (kind <= 5 || kind == 15) begin
        // usage page item, often carrying the target
        pre = PAGE_PREFIX | 8'($urandom_range(0, 3));
        nb  = (pre[1:0] == 2'd3) ? 4 : int'(pre[1:0]);
        val = $urandom_range(0, 1) ? {16'd0, target_page} : $urandom();
        desc_buf.push_back(pre);
        for (j = 0; j < nb; j++) desc_buf.push_back(val[8*j +: 8]);
      end else if (kind <= 11) begin
        // any other short item
        do pre = 8'($urandom_range(0, 255));
        while ((pre & LONG_MASK) == LONG_MASK || (pre & PAGE_MASK) == PAGE_PREFIX);
        nb = (pre[1:0] == 2'd3) ? 4 : int'(pre[1:0]);
        desc_buf.push_back(pre);
        for (j = 0; j < nb; j++) desc_buf.push_back(8'($urandom_range(0, 255)));
      end else if (kind <= 13) begin
        // long item, now and then with a long body
        nb = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 4);
        desc_buf.push_back(LONG_MASK | 8'($urandom_range(0, 15)));
        desc_buf.push_back(8'(nb));
        desc_buf.push_back(8'($urandom_range(0, 255)));
        for (j = 0; j < nb; j++) desc_buf.push_back(8'($urandom_range(0, 255)));
      end else begin
        desc_buf.push_back(8'($urandom_range(0, 255)));
      end
    end
    if ($urandom_range(0, 5) == 0) begin
      keep = $urandom_range(1, desc_buf.size());
      while (desc_buf.size() > keep) void'(desc_buf.pop_back());
    end
  endtask

  // phases of random descriptors, each with a fresh target page
  task automatic test_random_descriptors();
    int start_cnt;
    logic [15:0] page;
    start_cnt = bytes_sent;
    while (bytes_sent - start_cnt < RandomBytes) begin
      case ($urandom_range(0, 3))
        0:       page = 16'h0000;
        1:       page = 16'hFFFF;
        2:       page = 16'($urandom_range(0, 255));
        default: page = 16'($urandom_range(0, 65535));
      endcase
      program_target(page);
      // some phases run back to back with no idling at all
      quiet = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(5, 20)) begin
        build_random_descriptor();
        send_descriptor();
      end
      quiet = 1'b0;
    end
  endtask

  // run control
  initial begin
    rst_ni              <= 1'b0;
    in_valid_i          <= 1'b0;
    desc_byte_i         <= '0;
    last_byte_i         <= 1'b0;
    out_stall_i         <= 1'b0;
    cfg_valid_i         <= 1'b0;
    target_usage_page_i <= '0;
    target_page = '0;
    clear_parse_state();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_items();
    test_random_descriptors();

    wait_drained();
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #1_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
